// ===== design/sha256_stream_hasher_unit_macros.svh =====
// Assertion macros for the SHA-256 stream hasher unit.
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shs: same-cycle check failed");
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shs: next-cycle check failed");
`else
`define SHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/shs_pkg.sv =====
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package shs_pkg;

    typedef logic [31:0] t_word;

    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int ROUNDS      = 64;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_OFFSET  = 6'd56;
    localparam logic [5:0] LAST_FILL   = 6'd63;
    localparam logic [3:0] LEN_HI_WORD = 4'd14;
    localparam logic [3:0] LEN_LO_WORD = 4'd15;
    localparam logic [5:0] LAST_ROUND  = 6'd63;

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word big_sig0(t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word sml_sig0(t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word sml_sig1(t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

// ===== design/shs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module shs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/sha256_stream_hasher_unit.sv =====
// Streaming SHA-256 hasher: one byte per append item, digest as eight words.
// Append: bytes are taken while o_ready is high; a completed 64-byte block then holds input
//   through the chain reads, 64 rounds and write-back on the chain RAM's single ports.
// Finish: one padding block, or two when the length spills into a second block, then each
//   digest word is read, loaded and held until taken; appends go on while it drains.
// Reset: control clears; the chain RAM reads as the initial hash through a flag,
//   the message buffer is not cleared, and no clearing pass runs.
`default_nettype none
`include "sha256_stream_hasher_unit_macros.svh"
module sha256_stream_hasher_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_req_type,
    input  wire logic [7:0]          i_data_byte,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output shs_pkg::t_word           o_digest_word,
    output logic [2:0]               o_word_index,
    output logic                     o_last_word
);
    import shs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_WB, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
    } t_state;

    typedef enum logic [1:0] {
        BLK_DATA, BLK_PAD, BLK_PAD_LEN, BLK_LEN
    } t_blk;

    t_state      r_state;
    t_blk        r_kind;
    logic [3:0]  r_cnt;
    logic [5:0]  r_t;
    t_word       r_a [CHAIN_WORDS];
    t_word       r_w [BLOCK_WORDS];
    t_word       r_word;
    logic [5:0]  r_fill;
    logic [60:0] r_bytes;
    logic        r_init;
    logic [2:0]  r_rd_idx;
    logic [2:0]  r_oidx;
    logic        r_o_valid;
    t_word       r_o_word;
    logic [2:0]  r_o_index;
    logic        r_o_last;

    logic        out_phase;
    logic        in_acc;
    logic        app;
    t_word       word_new;
    t_word       partial;
    logic [63:0] bit_len;
    logic [3:0]  fw;
    logic [3:0]  wj;
    t_word       msg_rd;
    t_word       w_msg;
    t_word       w_t;
    t_word       t1;
    t_word       t2;
    t_word       ch_rd;
    t_word       ch_val;
    logic [2:0]  ch_raddr;
    logic        ch_we;
    t_word       ch_wdata;
    logic [3:0]  msg_raddr;
    logic        msg_we;

    assign out_phase = (r_state == S_OUT_RD) || (r_state == S_OUT_LD) ||
                       (r_state == S_OUT_WAIT);
    assign o_ready   = (r_state == S_IDLE) ||
                       (out_phase && !i_req_type && (r_fill != LAST_FILL));
    assign in_acc    = i_valid && o_ready;
    assign app       = in_acc && !i_req_type;

    // place the byte into its big-endian lane
    always_comb begin
        case (r_fill[1:0])
            2'd0:    word_new = {i_data_byte, r_word[23:0]};
            2'd1:    word_new = {r_word[31:24], i_data_byte, r_word[15:0]};
            2'd2:    word_new = {r_word[31:16], i_data_byte, r_word[7:0]};
            default: word_new = {r_word[31:8], i_data_byte};
        endcase
    end

    // partial word with the pad byte and zero fill behind the held bytes
    always_comb begin
        case (r_fill[1:0])
            2'd0:    partial = {PAD_BYTE, 24'h0};
            2'd1:    partial = {r_word[31:24], PAD_BYTE, 16'h0};
            2'd2:    partial = {r_word[31:16], PAD_BYTE, 8'h0};
            default: partial = {r_word[31:8], PAD_BYTE};
        endcase
    end

    assign msg_we    = app && (r_fill[1:0] == 2'd3);
    assign msg_raddr = (r_state == S_ROUND) ? (r_t[3:0] + 4'd1) : 4'd0;

    shs_ram #(
        .WIDTH (32),
        .DEPTH (BLOCK_WORDS)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (msg_we),
        .i_waddr (r_fill[5:2]),
        .i_wdata (word_new),
        .i_raddr (msg_raddr),
        .o_rdata (msg_rd)
    );

    assign bit_len = {r_bytes, 3'b000};
    assign fw      = r_fill[5:2];
    assign wj      = r_t[3:0];

    // message word for the first sixteen rounds, padding generated on the fly
    always_comb begin
        w_msg = '0;
        case (r_kind)
            BLK_DATA: w_msg = msg_rd;
            BLK_PAD, BLK_PAD_LEN: begin
                if (wj < fw) begin
                    w_msg = msg_rd;
                end else if (wj == fw) begin
                    w_msg = partial;
                end else if (r_kind == BLK_PAD_LEN && wj == LEN_HI_WORD) begin
                    w_msg = bit_len[63:32];
                end else if (r_kind == BLK_PAD_LEN && wj == LEN_LO_WORD) begin
                    w_msg = bit_len[31:0];
                end
            end
            default: begin
                if (wj == LEN_HI_WORD) begin
                    w_msg = bit_len[63:32];
                end else if (wj == LEN_LO_WORD) begin
                    w_msg = bit_len[31:0];
                end
            end
        endcase
    end

    always_comb begin
        if (r_t[5:4] == 2'b00) begin
            w_t = w_msg;
        end else begin
            w_t = r_w[0] + sml_sig0(r_w[1]) + r_w[9] + sml_sig1(r_w[14]);
        end
        t1 = r_a[7] + big_sig1(r_a[4]) + ((r_a[4] & r_a[5]) ^ (~r_a[4] & r_a[6]))
             + ROUND_K[r_t] + w_t;
        t2 = big_sig0(r_a[0]) + ((r_a[0] & r_a[1]) ^ (r_a[0] & r_a[2]) ^ (r_a[1] & r_a[2]));
    end

    always_comb begin
        case (r_state)
            S_LOAD, S_WB: ch_raddr = r_cnt[2:0];
            S_OUT_RD:     ch_raddr = r_oidx;
            default:      ch_raddr = 3'd0;
        endcase
    end

    assign ch_val   = r_init ? INIT_H[r_rd_idx] : ch_rd;
    assign ch_we    = (r_state == S_WB) && (r_cnt != 4'd0);
    assign ch_wdata = ch_val + r_a[0];

    shs_ram #(
        .WIDTH (32),
        .DEPTH (CHAIN_WORDS)
    ) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (r_rd_idx),
        .i_wdata (ch_wdata),
        .i_raddr (ch_raddr),
        .o_rdata (ch_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_kind    <= BLK_DATA;
            r_cnt     <= '0;
            r_t       <= '0;
            r_fill    <= '0;
            r_bytes   <= '0;
            r_init    <= 1'b1;
            r_oidx    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_idx <= ch_raddr;
            if (app) begin
                r_word  <= word_new;
                r_fill  <= r_fill + 6'd1;
                r_bytes <= r_bytes + 61'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (app && r_fill == LAST_FILL) begin
                        r_kind  <= BLK_DATA;
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else if (in_acc && i_req_type) begin
                        r_kind  <= (r_fill >= LEN_OFFSET) ? BLK_PAD : BLK_PAD_LEN;
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_cnt != 4'd0) begin
                        for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
                            r_a[i] <= r_a[i+1];
                        end
                        r_a[CHAIN_WORDS-1] <= ch_val;
                    end
                    if (r_cnt == 4'(CHAIN_WORDS)) begin
                        r_t     <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_ROUND: begin
                    r_a[7] <= r_a[6];
                    r_a[6] <= r_a[5];
                    r_a[5] <= r_a[4];
                    r_a[4] <= r_a[3] + t1;
                    r_a[3] <= r_a[2];
                    r_a[2] <= r_a[1];
                    r_a[1] <= r_a[0];
                    r_a[0] <= t1 + t2;
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[BLOCK_WORDS-1] <= w_t;
                    if (r_t == LAST_ROUND) begin
                        r_cnt   <= '0;
                        r_state <= S_WB;
                    end else begin
                        r_t <= r_t + 6'd1;
                    end
                end
                S_WB: begin
                    if (r_cnt != 4'd0) begin
                        for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
                            r_a[i] <= r_a[i+1];
                        end
                    end
                    if (r_cnt == 4'(CHAIN_WORDS)) begin
                        r_init <= 1'b0;
                        case (r_kind)
                            BLK_DATA: r_state <= S_IDLE;
                            BLK_PAD: begin
                                r_kind  <= BLK_LEN;
                                r_cnt   <= '0;
                                r_state <= S_LOAD;
                            end
                            default: begin
                                // message done: start the next one while the digest drains
                                r_fill  <= '0;
                                r_bytes <= '0;
                                r_oidx  <= '0;
                                r_state <= S_OUT_RD;
                            end
                        endcase
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_o_word  <= ch_val;
                    r_o_index <= r_oidx;
                    r_o_last  <= (r_oidx == 3'(CHAIN_WORDS - 1));
                    r_o_valid <= 1'b1;
                    r_state   <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (i_ready) begin
                        r_o_valid <= 1'b0;
                        if (r_o_last) begin
                            r_init  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx  <= r_oidx + 3'd1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_digest_word = r_o_word;
    assign o_word_index  = r_o_index;
    assign o_last_word   = r_o_last;

    `SHS_ASSERT_IMP(a_last_index, i_clk, i_rst_n, o_valid && o_last_word, o_word_index == 3'd7)
    `SHS_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, (r_state == S_LOAD) || (r_state == S_ROUND) || (r_state == S_WB), !o_ready)
    `SHS_ASSERT_NEXT(a_block_start, i_clk, i_rst_n, (r_state == S_IDLE) && in_acc && (i_req_type || (r_fill == LAST_FILL)), (r_state == S_LOAD) && (r_cnt == 4'd0))
    `SHS_ASSERT_IMP(a_digest_real, i_clk, i_rst_n, o_valid, !r_init)

endmodule
`default_nettype wire
